[sv/prqs_pkg.sv]
// Shared types, codes and helpers for the priority ready queue scheduler.
`timescale 1ns / 1ps

package prqs_pkg;

  localparam int ID_W       = 4;
  localparam int PRIO_W     = 8;
  localparam int COUNT_W    = 5;
  localparam int COLOR_W    = 4;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 24;

  localparam logic OP_INSERT   = 1'b0;
  localparam logic OP_SCHEDULE = 1'b1;

  localparam logic [COLOR_W-1:0] COLOR_BASE = 4'd10;
  localparam logic [ID_W-1:0]    COLOR_MOD  = 4'd6;
  localparam logic [ID_W-1:0]    COLOR_MOD2 = ID_W'(2 * COLOR_MOD);

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic [COUNT_W-1:0] queue_count;
    logic [COLOR_W-1:0] display_color;
    logic               full_drop;
    logic               queue_empty_error;
    logic               chosen_valid;
    logic [PRIO_W-1:0]  chosen_priority;
    logic [ID_W-1:0]    chosen_id;
  } result_t;

  function automatic logic [COLOR_W-1:0] color_of(input logic [ID_W-1:0] id);
    logic [ID_W-1:0] rem;
    rem = id;
    if (rem >= COLOR_MOD2) begin
      rem = rem - COLOR_MOD2;
    end else if (rem >= COLOR_MOD) begin
      rem = rem - COLOR_MOD;
    end
    return COLOR_BASE + COLOR_W'(rem);
  endfunction

endpackage

[sv/priority_ready_queue_scheduler_unit.sv]
// Top level: stable priority ready queue held in a synchronous memory ring.
`timescale 1ns / 1ps
//
// Usage: items enter on the in_ stream, one result item per input item leaves
// on the out_ stream. in_tuser selects insert (0) or schedule (1).
// The queue lives in one memory of QUEUE_DEPTH entries used as a ring from a
// head pointer; a pop advances the head. An insert walks from the tail towards
// the head, one memory read and one write per entry with a lower priority,
// moving each such entry up by one slot, then writes the new entry.
// A schedule with still_ready set first runs the insert walk and then pops.
// Each moved entry passes through S_INS (read) and S_CMP (compare and write),
// since the memory read is registered.
// One item is in work at a time; the next item is taken while the previous
// result still waits in the output register.
// Reset empties the queue at once (occupancy and head cleared); no clearing
// pass. When the receiver stalls, the finished result holds in the output
// register and the block holds the following item until that register frees.
module priority_ready_queue_scheduler_unit #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [3:0] task_id, [11:4] task_priority, [12] still_ready, [15:13] zero
  input  logic [prqs_pkg::IN_DATA_W-1:0]     in_tdata,
  // [0] operation
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [3:0] chosen_id, [11:4] chosen_priority, [12] chosen_valid,
  // [13] queue_empty_error, [14] full_drop, [18:15] display_color,
  // [23:19] queue_count
  output logic [prqs_pkg::OUT_DATA_W-1:0]    out_tdata
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW:0]   DEPTH_W = (CW + 1)'(QUEUE_DEPTH);
  localparam logic [CW-1:0] FULL_W  = CW'(QUEUE_DEPTH);
  localparam logic [PW-1:0] LAST_W  = PW'(QUEUE_DEPTH - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_POP  = 3'd3;
  localparam logic [2:0] S_POPD = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  prqs_pkg::entry_t mem_r [QUEUE_DEPTH];
  prqs_pkg::entry_t rd_data_r;
  prqs_pkg::result_t res_r, res_nxt;
  prqs_pkg::result_t out_r, out_nxt;

  logic [2:0]                   state_r, state_nxt;
  logic                         op_r, op_nxt;
  logic [prqs_pkg::ID_W-1:0]    id_r, id_nxt;
  logic [prqs_pkg::PRIO_W-1:0]  prio_r, prio_nxt;
  logic [CW-1:0]                k_r, k_nxt;
  logic [CW-1:0]                occ_r, occ_nxt;
  logic [PW-1:0]                head_r, head_nxt;
  logic                         out_valid_r, out_valid_nxt;

  logic                         wr_en;
  logic [PW-1:0]                wr_addr;
  logic [PW-1:0]                rd_addr;
  prqs_pkg::entry_t             wr_data;
  logic [CW+4:0]                occ_ext;
  logic                         in_fire;

  function automatic logic [PW-1:0] ring(input logic [PW-1:0] base,
                                         input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW + 1)'(base) + (CW + 1)'(off);
    if (sum >= DEPTH_W) begin
      sum = sum - DEPTH_W;
    end
    return PW'(sum);
  endfunction

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;

  assign wr_addr = ring(head_r, k_r);
  assign rd_addr = (state_r == S_POP) ? head_r : ring(head_r, k_r - CW'(1));
  assign occ_ext = {5'b0, occ_r};

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    id_nxt        = id_r;
    prio_nxt      = prio_r;
    k_nxt         = k_r;
    occ_nxt       = occ_r;
    head_nxt      = head_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    wr_en         = 1'b0;
    wr_data.id    = id_r;
    wr_data.prio  = prio_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt   = in_tuser;
          id_nxt   = in_tdata[3:0];
          prio_nxt = in_tdata[11:4];
          k_nxt    = occ_r;
          res_nxt  = '0;
          if (in_tuser == prqs_pkg::OP_INSERT || in_tdata[12]) begin
            if (occ_r == FULL_W) begin
              res_nxt.full_drop = 1'b1;
              state_nxt = (in_tuser == prqs_pkg::OP_SCHEDULE) ? S_POP : S_DONE;
            end else begin
              state_nxt = S_INS;
            end
          end else begin
            state_nxt = S_POP;
          end
        end
      end
      S_INS: begin
        if (k_r == '0) begin
          wr_en     = 1'b1;
          occ_nxt   = occ_r + CW'(1);
          state_nxt = (op_r == prqs_pkg::OP_SCHEDULE) ? S_POP : S_DONE;
        end else begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        wr_en = 1'b1;
        if (rd_data_r.prio < prio_r) begin
          wr_data   = rd_data_r;
          k_nxt     = k_r - CW'(1);
          state_nxt = S_INS;
        end else begin
          occ_nxt   = occ_r + CW'(1);
          state_nxt = (op_r == prqs_pkg::OP_SCHEDULE) ? S_POP : S_DONE;
        end
      end
      S_POP: begin
        if (occ_r == '0) begin
          res_nxt.queue_empty_error = 1'b1;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_POPD;
        end
      end
      S_POPD: begin
        res_nxt.chosen_id       = rd_data_r.id;
        res_nxt.chosen_priority = rd_data_r.prio;
        res_nxt.chosen_valid    = 1'b1;
        head_nxt  = (head_r == LAST_W) ? '0 : head_r + PW'(1);
        occ_nxt   = occ_r - CW'(1);
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_nxt               = res_r;
          out_nxt.display_color = prqs_pkg::color_of(res_r.chosen_id);
          out_nxt.queue_count   = occ_ext[4:0];
          out_valid_nxt         = 1'b1;
          state_nxt             = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    id_r   <= id_nxt;
    prio_r <= prio_nxt;
    k_r    <= k_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[verif/priority_ready_queue_scheduler_unit_tb.sv]
// Testbench for the priority ready queue scheduler: directed and random streams checked against a queue model.
`timescale 1ns / 1ps

module priority_ready_queue_scheduler_unit_tb;

  localparam int CLK_PERIOD     = 10;
  localparam int QUEUE_DEPTH    = 16;
  localparam int RANDOM_ITEMS   = 1230;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int TAIL_CYCLES    = 100;

  localparam logic [prqs_pkg::PRIO_W-1:0] FILL_PRIO [QUEUE_DEPTH] = '{
    8'd128, 8'd0, 8'd255, 8'd128, 8'd64, 8'd128, 8'd0, 8'd255,
    8'd1, 8'd128, 8'd254, 8'd64, 8'd0, 8'd128, 8'd255, 8'd127
  };

  typedef struct {
    logic                        op;
    logic [prqs_pkg::ID_W-1:0]   id;
    logic [prqs_pkg::PRIO_W-1:0] prio;
    logic                        requeue;
    bit                          drain_first;
  } sched_req_t;

  typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [prqs_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic                            in_tuser = prqs_pkg::OP_INSERT;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [prqs_pkg::OUT_DATA_W-1:0] out_tdata;

  sched_req_t        stim_items[$];
  prqs_pkg::result_t expected_results[$];
  prqs_pkg::entry_t  ready_q[$];

  sched_req_t next_req;
  bit         in_taken = 1'b0;
  bit         out_taken = 1'b0;
  bit         gap_drawn = 1'b0;
  bit         calm = 1'b0;
  int         in_gap = 0;
  int         out_wait = 0;
  int         quiet_cycles = 0;
  int         mismatches = 0;
  int         result_no = 0;

  priority_ready_queue_scheduler_unit #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic int pause_draw();
    return calm ? 0 : int'($urandom_range(0, 3));
  endfunction

  function automatic prqs_pkg::result_t ready_queue_step(
      input logic op, input logic [prqs_pkg::ID_W-1:0] id,
      input logic [prqs_pkg::PRIO_W-1:0] prio, input logic requeue);
    prqs_pkg::result_t r;
    prqs_pkg::entry_t  e;
    int                pos;
    r = '0;
    e.id = id;
    e.prio = prio;
    if (op == prqs_pkg::OP_INSERT || requeue) begin
      if (ready_q.size() >= QUEUE_DEPTH) begin
        r.full_drop = 1'b1;
      end else begin
        pos = 0;
        while (pos < ready_q.size() && ready_q[pos].prio >= prio) pos++;
        ready_q.insert(pos, e);
      end
    end
    if (op == prqs_pkg::OP_SCHEDULE) begin
      if (ready_q.size() == 0) begin
        r.queue_empty_error = 1'b1;
      end else begin
        e = ready_q.pop_front();
        r.chosen_id = e.id;
        r.chosen_priority = e.prio;
        r.chosen_valid = 1'b1;
      end
    end
    r.display_color = prqs_pkg::COLOR_BASE + (r.chosen_id % prqs_pkg::COLOR_MOD);
    r.queue_count = prqs_pkg::COUNT_W'(ready_q.size());
    return r;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("%0t: result %0d %s got %0d want %0d", $realtime, result_no, field, got, want);
    mismatches++;
  endtask

  task automatic add_req(input logic op, input logic [prqs_pkg::ID_W-1:0] id,
                         input logic [prqs_pkg::PRIO_W-1:0] prio, input logic requeue,
                         input bit drain_first);
    sched_req_t r;
    r.op = op;
    r.id = id;
    r.prio = prio;
    r.requeue = requeue;
    r.drain_first = drain_first;
    stim_items.push_back(r);
  endtask

  // Sender: send the next item once the last is taken, its gap is over and, if drain_first, no result waits.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (stim_items.size() == 0) begin
        in_tvalid <= 1'b0;
      end else begin
        if (!gap_drawn) begin
          in_gap = pause_draw();
          gap_drawn = 1'b1;
        end
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (stim_items[0].drain_first && expected_results.size() != 0) begin
          in_tvalid <= 1'b0;
        end else begin
          next_req = stim_items.pop_front();
          in_tdata <= {3'b000, next_req.requeue, next_req.prio, next_req.id};
          in_tuser <= next_req.op;
          in_tvalid <= 1'b1;
          gap_drawn = 1'b0;
        end
      end
    end
  end

  // Receiver: stall a drawn number of cycles before taking each result item.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_taken) out_wait = pause_draw();
      if (out_wait > 0) begin
        out_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    prqs_pkg::result_t got;
    prqs_pkg::result_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
      out_taken <= 1'b0;
    end else begin
      in_taken <= in_tvalid && in_tready;
      out_taken <= out_tvalid && out_tready;
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected item", int'(got), 0);
        end else begin
          want = expected_results.pop_front();
          if (got.chosen_id !== want.chosen_id)
            report_mismatch("chosen_id", int'(got.chosen_id), int'(want.chosen_id));
          if (got.chosen_priority !== want.chosen_priority)
            report_mismatch("chosen_priority", int'(got.chosen_priority),
                            int'(want.chosen_priority));
          if (got.chosen_valid !== want.chosen_valid)
            report_mismatch("chosen_valid", int'(got.chosen_valid), int'(want.chosen_valid));
          if (got.queue_empty_error !== want.queue_empty_error)
            report_mismatch("queue_empty_error", int'(got.queue_empty_error),
                            int'(want.queue_empty_error));
          if (got.full_drop !== want.full_drop)
            report_mismatch("full_drop", int'(got.full_drop), int'(want.full_drop));
          if (got.display_color !== want.display_color)
            report_mismatch("display_color", int'(got.display_color),
                            int'(want.display_color));
          if (got.queue_count !== want.queue_count)
            report_mismatch("queue_count", int'(got.queue_count), int'(want.queue_count));
        end
        result_no++;
      end
      if (in_tvalid && in_tready) begin
        expected_results.push_back(ready_queue_step(in_tuser, in_tdata[3:0],
                                                    in_tdata[11:4], in_tdata[12]));
        if ($urandom_range(0, 63) == 0) calm = !calm;
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    mix_t                        mix;
    int                          issued;
    int                          run_len;
    int                          sched_tenths;
    bit                          narrow;
    logic                        op;
    logic [prqs_pkg::PRIO_W-1:0] prio;
    logic                        requeue;

    // Pop an empty queue, then requeue into an empty queue.
    add_req(prqs_pkg::OP_SCHEDULE, 4'd0, 8'd0, 1'b0, 1'b0);
    add_req(prqs_pkg::OP_SCHEDULE, 4'd15, 8'd255, 1'b1, 1'b0);
    // Fill with ties and extremes; the ignored requeue bit toggles.
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      add_req(prqs_pkg::OP_INSERT, prqs_pkg::ID_W'(i), FILL_PRIO[i], i[0], 1'b0);
    end
    // Insert and requeue into a full queue, then a plain pop.
    add_req(prqs_pkg::OP_INSERT, 4'd9, 8'd200, 1'b1, 1'b0);
    add_req(prqs_pkg::OP_SCHEDULE, 4'd5, 8'd255, 1'b1, 1'b0);
    add_req(prqs_pkg::OP_SCHEDULE, 4'd10, 8'd3, 1'b0, 1'b0);
    add_req(prqs_pkg::OP_INSERT, 4'd12, 8'd129, 1'b0, 1'b1);

    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      run_len = $urandom_range(10, 40);
      mix = mix_t'($urandom_range(0, 2));
      narrow = ($urandom_range(0, 1) == 1);
      unique case (mix)
        MIX_FILL:  sched_tenths = 2;
        MIX_DRAIN: sched_tenths = 8;
        default:   sched_tenths = 5;
      endcase
      repeat (run_len) begin
        op = ($urandom_range(0, 9) < sched_tenths) ? prqs_pkg::OP_SCHEDULE
                                                   : prqs_pkg::OP_INSERT;
        if (narrow) prio = ($urandom_range(0, 7) == 0) ? 8'hFF
                                                       : prqs_pkg::PRIO_W'($urandom_range(0, 3));
        else prio = prqs_pkg::PRIO_W'($urandom_range(0, 255));
        requeue = (mix == MIX_DRAIN) ? ($urandom_range(0, 3) == 0)
                                     : ($urandom_range(0, 1) == 1);
        add_req(op, prqs_pkg::ID_W'($urandom_range(0, 15)), prio, requeue,
                $urandom_range(0, 199) == 0);
        issued++;
      end
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (stim_items.size() != 0 || in_tvalid || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
